/* hdl/espc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the encoder speed PI controller.
package espc_pkg;

   localparam int unsigned NUM_W      = 17;
   localparam int unsigned DIV_CNT_W  = 5;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);

   localparam logic [15:0]      LOW_LIMIT_RST  = 16'd200;
   localparam logic [15:0]      HIGH_LIMIT_RST = 16'd15625;
   localparam logic [3:0]       PROP_GAIN_RST  = 4'd2;
   localparam logic [3:0]       INTEG_GAIN_RST = 4'd2;
   localparam logic [2:0]       OUT_SHIFT_RST  = 3'd3;
   localparam logic [NUM_W-1:0] NUMERATOR_RST  = 17'd78125;

   localparam logic [9:0]  SETPOINT_MIN = 10'd10;
   localparam logic [9:0]  SETPOINT_MAX = 10'd120;
   localparam logic [15:0] SPEED_MAX    = 16'hFFFF;
   localparam logic [7:0]  DRIVE_MAX    = 8'd255;
   localparam logic [7:0]  FINE_SCALE   = 8'd10;
   localparam logic [15:0] FINE_OFFSET  = 16'd9;
   localparam logic [1:0]  GROUP_LAST   = 2'd3;

   typedef enum logic [1:0] {
      FUNC_PERIOD   = 2'd0,
      FUNC_TICK     = 2'd1,
      FUNC_SETPOINT = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      CSR_LOW_LIMIT  = 3'd0,
      CSR_HIGH_LIMIT = 3'd1,
      CSR_PROP_GAIN  = 3'd2,
      CSR_INTEG_GAIN = 3'd3,
      CSR_OUT_SHIFT  = 3'd4,
      CSR_NUMERATOR  = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] period_ticks;
      logic [9:0]  fine_adc;
      logic [9:0]  new_setpoint;
   } req_type;

   typedef struct packed {
      logic [7:0]  drive;
      logic [15:0] speed_rpm;
   } rsp_type;

   typedef struct packed {
      logic [15:0]      low_period_limit;
      logic [15:0]      high_period_limit;
      logic [3:0]       prop_gain;
      logic [3:0]       integ_gain;
      logic [2:0]       out_shift;
      logic [NUM_W-1:0] speed_numerator;
   } cfg_type;

   typedef struct packed {
      logic load_item;
      logic take_period;
      logic med_step;
      logic div_step;
      logic speed_load;
      logic reg_err;
      logic reg_sum;
      logic reg_drive;
      logic set_sp;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       in_band;
      logic       window_done;
      logic       med_found;
      logic       div_last;
      logic       out_free;
   } status_type;

endpackage

/* hdl/espc_csr.sv */
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
module espc_csr
   import espc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   logic        wr_en;
   logic [2:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_period_limit  <= LOW_LIMIT_RST;
         cfg_ff.high_period_limit <= HIGH_LIMIT_RST;
         cfg_ff.prop_gain         <= PROP_GAIN_RST;
         cfg_ff.integ_gain        <= INTEG_GAIN_RST;
         cfg_ff.out_shift         <= OUT_SHIFT_RST;
         cfg_ff.speed_numerator   <= NUMERATOR_RST;
      end else if (wr_en) begin
         case (reg_idx)
            CSR_LOW_LIMIT:  cfg_ff.low_period_limit  <= pwdata[15:0];
            CSR_HIGH_LIMIT: cfg_ff.high_period_limit <= pwdata[15:0];
            CSR_PROP_GAIN:  cfg_ff.prop_gain         <= pwdata[3:0];
            CSR_INTEG_GAIN: cfg_ff.integ_gain        <= pwdata[3:0];
            CSR_OUT_SHIFT:  cfg_ff.out_shift         <= pwdata[2:0];
            CSR_NUMERATOR:  cfg_ff.speed_numerator   <= pwdata[NUM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         CSR_LOW_LIMIT:  prdata = CSR_DATA_W'(cfg_ff.low_period_limit);
         CSR_HIGH_LIMIT: prdata = CSR_DATA_W'(cfg_ff.high_period_limit);
         CSR_PROP_GAIN:  prdata = CSR_DATA_W'(cfg_ff.prop_gain);
         CSR_INTEG_GAIN: prdata = CSR_DATA_W'(cfg_ff.integ_gain);
         CSR_OUT_SHIFT:  prdata = CSR_DATA_W'(cfg_ff.out_shift);
         CSR_NUMERATOR:  prdata = CSR_DATA_W'(cfg_ff.speed_numerator);
         default:        prdata = '0;
      endcase
   end

endmodule

/* hdl/espc_dp.sv */
`timescale 1ns / 1ps
// Datapath: period grouping, median window, divider, PI arithmetic and output register.
module espc_dp
   import espc_pkg::*;
#(
   parameter int unsigned MEDIAN_WINDOW = 5
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  cfg_type    cfg,
   input  cmd_type    cmd,
   output status_type status
);

   localparam int unsigned FILL_W = $clog2(MEDIAN_WINDOW);
   localparam int unsigned CNT_W  = $clog2(MEDIAN_WINDOW + 1);
   localparam logic [FILL_W-1:0] FILL_LAST  = FILL_W'(MEDIAN_WINDOW - 1);
   localparam logic [CNT_W-1:0]  MEDIAN_POS = CNT_W'(MEDIAN_WINDOW / 2);

   req_type              item_ff;
   logic [15:0]          sum_ff;
   logic [1:0]           group_ff;
   logic [FILL_W-1:0]    fill_ff;
   logic [15:0]          window_ff [MEDIAN_WINDOW];
   logic [FILL_W-1:0]    med_idx_ff;
   logic [15:0]          den_ff;
   logic [15:0]          rem_ff;
   logic [NUM_W-1:0]     quo_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [15:0]          speed_ff;
   logic [6:0]           setpoint_ff;
   logic [15:0]          err_ff;
   logic [15:0]          integ_ff;
   logic [15:0]          pi_sum_ff;
   logic [7:0]           drive_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic [15:0]      sum_in;
   logic [15:0]      cand;
   logic [CNT_W-1:0] lt_cnt;
   logic [CNT_W-1:0] le_cnt;
   logic [NUM_W-1:0] div_shift;
   logic             div_ge;
   logic [NUM_W-1:0] div_diff;
   logic [7:0]       fine_mul;
   logic [15:0]      err_in;
   logic [19:0]      prod_p;
   logic [19:0]      prod_i;
   logic [15:0]      shifted;
   logic             sp_ok;

   assign sum_in = sum_ff + item_ff.period_ticks;
   assign cand   = window_ff[med_idx_ff];

   always_comb begin
      lt_cnt = '0;
      le_cnt = '0;
      for (int j = 0; j < MEDIAN_WINDOW; j++) begin
         lt_cnt = lt_cnt + CNT_W'(window_ff[j] < cand);
         le_cnt = le_cnt + CNT_W'(window_ff[j] <= cand);
      end
   end

   assign div_shift = {rem_ff, quo_ff[NUM_W-1]};
   assign div_ge    = div_shift >= NUM_W'(den_ff);
   assign div_diff  = div_shift - NUM_W'(den_ff);

   assign fine_mul = 8'(item_ff.fine_adc[9:6]) * FINE_SCALE;
   assign err_in   = 16'(setpoint_ff) - speed_ff + 16'(fine_mul[7:3]) - FINE_OFFSET;
   assign prod_p   = 20'(cfg.prop_gain) * 20'(err_ff);
   assign prod_i   = 20'(cfg.integ_gain) * 20'(integ_ff);
   assign shifted  = pi_sum_ff >> cfg.out_shift;
   assign sp_ok    = (item_ff.new_setpoint >= SETPOINT_MIN) &&
                     (item_ff.new_setpoint <= SETPOINT_MAX);

   assign status.func        = item_ff.func;
   assign status.in_band     = (item_ff.period_ticks > cfg.low_period_limit) &&
                               (item_ff.period_ticks < cfg.high_period_limit);
   assign status.window_done = (group_ff == GROUP_LAST) && (fill_ff == FILL_LAST);
   assign status.med_found   = (lt_cnt <= MEDIAN_POS) && (le_cnt > MEDIAN_POS);
   assign status.div_last    = (div_cnt_ff == DIV_LAST);
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
      if (cmd.take_period && (group_ff == GROUP_LAST)) begin
         window_ff[fill_ff] <= {2'b00, sum_in[15:2]};
      end
      if (cmd.take_period) begin
         med_idx_ff <= '0;
      end else if (cmd.med_step && !status.med_found) begin
         med_idx_ff <= med_idx_ff + 1'b1;
      end
      if (cmd.med_step && status.med_found) begin
         den_ff     <= cand;
         rem_ff     <= '0;
         quo_ff     <= cfg.speed_numerator;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= div_ge ? div_diff[15:0] : div_shift[15:0];
         quo_ff     <= {quo_ff[NUM_W-2:0], div_ge};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
      if (cmd.reg_err) begin
         err_ff <= err_in;
      end
      if (cmd.reg_sum) begin
         pi_sum_ff <= prod_p[15:0] + prod_i[15:0];
      end
      if (cmd.out_load) begin
         rsp_ff.drive     <= drive_ff;
         rsp_ff.speed_rpm <= speed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         group_ff     <= '0;
         fill_ff      <= '0;
         speed_ff     <= '0;
         setpoint_ff  <= '0;
         integ_ff     <= '0;
         drive_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.take_period) begin
            if (group_ff == GROUP_LAST) begin
               group_ff <= '0;
               sum_ff   <= '0;
               fill_ff  <= (fill_ff == FILL_LAST) ? '0 : fill_ff + 1'b1;
            end else begin
               group_ff <= group_ff + 1'b1;
               sum_ff   <= sum_in;
            end
         end
         if (cmd.speed_load) begin
            speed_ff <= quo_ff[NUM_W-1] ? SPEED_MAX : quo_ff[15:0];
         end
         if (cmd.reg_err) begin
            integ_ff <= integ_ff + err_in;
         end else if (cmd.set_sp && sp_ok) begin
            integ_ff <= '0;
         end
         if (cmd.set_sp && sp_ok) begin
            setpoint_ff <= item_ff.new_setpoint[6:0];
         end
         if (cmd.reg_drive) begin
            if (pi_sum_ff[15]) begin
               drive_ff <= '0;
            end else begin
               drive_ff <= (shifted > 16'(DRIVE_MAX)) ? DRIVE_MAX : shifted[7:0];
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_speed_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.speed_load |=> $stable(speed_ff))
      else $error("speed changed without a speed load");

   a_integ_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.reg_err && !cmd.set_sp |=> $stable(integ_ff))
      else $error("integral changed outside a regulator or setpoint transaction");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff && (rsp_ff.drive == $past(drive_ff)))
      else $error("result register not loaded");

endmodule

/* hdl/espc_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine that sequences each transaction through the datapath.
module espc_ctrl
   import espc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_DECODE    = 8'b0000_0010,
      S_MEDIAN    = 8'b0000_0100,
      S_DIV       = 8'b0000_1000,
      S_SPEED     = 8'b0001_0000,
      S_REG_SUM   = 8'b0010_0000,
      S_REG_DRIVE = 8'b0100_0000,
      S_DONE      = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.func == FUNC_PERIOD) begin
               if (status.in_band) begin
                  cmd.take_period = 1'b1;
                  state_in        = status.window_done ? S_MEDIAN : S_DONE;
               end else begin
                  state_in = S_DONE;
               end
            end else if (status.func == FUNC_TICK) begin
               cmd.reg_err = 1'b1;
               state_in    = S_REG_SUM;
            end else if (status.func == FUNC_SETPOINT) begin
               cmd.set_sp = 1'b1;
               state_in   = S_DONE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MEDIAN: begin
            cmd.med_step = 1'b1;
            if (status.med_found) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_SPEED;
            end
         end
         S_SPEED: begin
            cmd.speed_load = 1'b1;
            state_in       = S_DONE;
         end
         S_REG_SUM: begin
            cmd.reg_sum = 1'b1;
            state_in    = S_REG_DRIVE;
         end
         S_REG_DRIVE: begin
            cmd.reg_drive = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_DECODE)
      else $error("accepted transaction did not reach decode");

   a_div_to_speed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) && status.div_last |=> state_ff == S_SPEED)
      else $error("divider finished without loading the speed");

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !cmd.load_item && !cmd.take_period && !cmd.div_step)
      else $error("result loaded while work is still issued");

endmodule

/* hdl/encoder_speed_pi_controller.sv */
`timescale 1ns / 1ps
// Top level: encoder speed loop with median-filtered speed and PI drive regulator.
// A period or setpoint transaction runs from acceptance through the decode and done states,
// with the result loaded on leaving done; a regulator tick also passes the sum and drive states.
// A period that completes the median window adds the median search, the bit-serial divider
// and the speed load; done waits while a held result is stalled.
// Synchronous reset clears the loop state and restores the register defaults;
// the window entries are not cleared and are only read after all have been written.
module encoder_speed_pi_controller
   import espc_pkg::*;
#(
   parameter int unsigned MEDIAN_WINDOW = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   espc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   espc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   espc_dp #(
      .MEDIAN_WINDOW (MEDIAN_WINDOW)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

/* tb/tb_encoder_speed_pi_controller.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the encoder speed PI controller with a cycle-free shadow model.
module tb_encoder_speed_pi_controller;
   import espc_pkg::*;

   localparam int unsigned WINDOW_LEN = 5;
   localparam int unsigned LONG_HOLD  = 300;
   localparam logic [1:0]  FUNC_UNUSED = 2'd3;

   typedef enum int unsigned {
      GROUP_SPREAD,
      GROUP_WRAP,
      GROUP_LONG,
      GROUP_SHORT
   } group_style_type;

   class speed_loop_shadow;
      logic [15:0] low_limit;
      logic [15:0] high_limit;
      logic [3:0]  kp;
      logic [3:0]  ki;
      logic [2:0]  shift;
      logic [16:0] numerator;
      logic [15:0] period_acc;
      logic [1:0]  group_cnt;
      logic [15:0] window [WINDOW_LEN];
      logic [3:0]  fill;
      logic [15:0] speed;
      logic [15:0] integral;
      logic [7:0]  drive;
      logic [6:0]  setpoint;
      rsp_type     drive_speed_due [$];
      int unsigned mismatches;

      function new();
         low_limit  = LOW_LIMIT_RST;
         high_limit = HIGH_LIMIT_RST;
         kp         = PROP_GAIN_RST;
         ki         = INTEG_GAIN_RST;
         shift      = OUT_SHIFT_RST;
         numerator  = NUMERATOR_RST;
         period_acc = '0;
         group_cnt  = '0;
         fill       = '0;
         speed      = '0;
         integral   = '0;
         drive      = '0;
         setpoint   = '0;
         mismatches = 0;
         foreach (window[i]) window[i] = '0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [31:0] value);
         case (idx)
            CSR_LOW_LIMIT:  low_limit  = value[15:0];
            CSR_HIGH_LIMIT: high_limit = value[15:0];
            CSR_PROP_GAIN:  kp         = value[3:0];
            CSR_INTEG_GAIN: ki         = value[3:0];
            CSR_OUT_SHIFT:  shift      = value[2:0];
            CSR_NUMERATOR:  numerator  = value[16:0];
            default: ;
         endcase
      endfunction

      function bit add_period(logic [15:0] p);
         logic [15:0] sorted [WINDOW_LEN];
         logic [15:0] t;
         logic [15:0] med;
         logic [16:0] quot;
         if (!(p > low_limit && p < high_limit)) return 1'b0;
         period_acc = period_acc + p;
         group_cnt  = group_cnt + 2'd1;
         if (group_cnt != 2'd0) return 1'b1;
         window[fill] = period_acc >> 2;
         period_acc   = '0;
         fill         = fill + 4'd1;
         if (fill == WINDOW_LEN) begin
            sorted = window;
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
               for (int j = 0; j < WINDOW_LEN - 1 - i; j++) begin
                  if (sorted[j] > sorted[j+1]) begin
                     t           = sorted[j];
                     sorted[j]   = sorted[j+1];
                     sorted[j+1] = t;
                  end
               end
            end
            med = sorted[WINDOW_LEN / 2];
            if (med == 16'd0) begin
               speed = SPEED_MAX;
            end else begin
               quot  = numerator / med;
               speed = (quot > 17'(SPEED_MAX)) ? SPEED_MAX : quot[15:0];
            end
            fill = '0;
         end
         return 1'b1;
      endfunction

      function void run_tick(logic [9:0] adc);
         logic [4:0]  fine_pos;
         logic [15:0] err;
         logic [15:0] pi_sum;
         logic [15:0] shifted;
         fine_pos = 5'((32'(adc >> 6) * 32'(FINE_SCALE)) >> 3);
         err      = 16'(setpoint) - speed + 16'(fine_pos) - FINE_OFFSET;
         integral = integral + err;
         pi_sum   = 16'(32'(kp) * 32'(err) + 32'(ki) * 32'(integral));
         if (pi_sum[15]) begin
            drive = 8'd0;
         end else begin
            shifted = pi_sum >> shift;
            drive   = (shifted > 16'(DRIVE_MAX)) ? DRIVE_MAX : shifted[7:0];
         end
      endfunction

      function bit take_item(req_type it);
         bit      effective;
         rsp_type want;
         effective = 1'b0;
         case (it.func)
            FUNC_PERIOD: begin
               effective = add_period(it.period_ticks);
            end
            FUNC_TICK: begin
               run_tick(it.fine_adc);
               effective = 1'b1;
            end
            FUNC_SETPOINT: begin
               if (it.new_setpoint >= SETPOINT_MIN && it.new_setpoint <= SETPOINT_MAX) begin
                  setpoint  = 7'(it.new_setpoint);
                  integral  = '0;
                  effective = 1'b1;
               end
            end
            default: ;
         endcase
         want.drive     = drive;
         want.speed_rpm = speed;
         drive_speed_due.push_back(want);
         return effective;
      endfunction

      function void flag(string what, int unsigned want, int unsigned got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch on %s, expected %0d, got %0d", $time, what, want, got);
      endfunction

      function void check_output(rsp_type got);
         rsp_type want;
         if (drive_speed_due.size() == 0) begin
            flag("transaction with nothing pending", 0, got.speed_rpm);
            return;
         end
         want = drive_speed_due.pop_front();
         if (got.drive !== want.drive) flag("drive", want.drive, got.drive);
         if (got.speed_rpm !== want.speed_rpm) flag("speed_rpm", want.speed_rpm, got.speed_rpm);
      endfunction

      function int unsigned outstanding();
         return drive_speed_due.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   speed_loop_shadow loop_shadow;
   bit               no_gaps;
   bit               hold_request;
   group_style_type  group_style;
   int unsigned      style_left;

   encoder_speed_pi_controller #(
      .MEDIAN_WINDOW(WINDOW_LEN)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb_encoder_speed_pi_controller: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) loop_shadow.check_output(rsp_data);
   end

   initial begin : result_side
      int unsigned len;
      int unsigned r;
      bit          hold;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         hold = 1'b0;
         len  = 1;
         if (hold_request) begin
            hold         = 1'b1;
            len          = LONG_HOLD;
            hold_request = 1'b0;
         end else if (!no_gaps) begin
            r = $urandom_range(99, 0);
            if (r < 60) begin
               len = $urandom_range(8, 1);
            end else if (r < 95) begin
               hold = 1'b1;
               len  = $urandom_range(3, 1);
            end else begin
               hold = 1'b1;
               len  = $urandom_range(40, 10);
            end
         end
         rsp_stall <= hold;
         repeat (len) @(posedge clock);
      end
   end

   task automatic send_item(input req_type it);
      int unsigned r;
      int unsigned gap;
      req_data  <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      void'(loop_shadow.take_item(it));
      gap = 0;
      if (!no_gaps) begin
         r = $urandom_range(99, 0);
         if (r < 55) gap = 0;
         else if (r < 90) gap = $urandom_range(3, 1);
         else if (r < 97) gap = $urandom_range(10, 4);
         else gap = $urandom_range(50, 20);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic push_item(logic [1:0] func, logic [15:0] period, logic [9:0] adc,
                            logic [9:0] sp);
      req_type it;
      it.func         = func;
      it.period_ticks = period;
      it.fine_adc     = adc;
      it.new_setpoint = sp;
      send_item(it);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (loop_shadow.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      loop_shadow.write_reg(idx, value);
   endtask

   task automatic apply_cfg(logic [15:0] lo, logic [15:0] hi, logic [3:0] kp, logic [3:0] ki,
                            logic [2:0] sh, logic [16:0] num);
      settle();
      write_csr(CSR_LOW_LIMIT, 32'(lo));
      write_csr(CSR_HIGH_LIMIT, 32'(hi));
      write_csr(CSR_PROP_GAIN, 32'(kp));
      write_csr(CSR_INTEG_GAIN, 32'(ki));
      write_csr(CSR_OUT_SHIFT, 32'(sh));
      write_csr(CSR_NUMERATOR, 32'(num));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_item();
      req_type     it;
      int unsigned r;
      int unsigned lo;
      int unsigned hi;
      lo              = loop_shadow.low_limit;
      hi              = loop_shadow.high_limit;
      it.func         = FUNC_PERIOD;
      it.period_ticks = 16'($urandom);
      it.fine_adc     = 10'($urandom);
      it.new_setpoint = 10'($urandom_range(999, 0));
      r = $urandom_range(99, 0);
      if (r < 60) begin
         if (hi > lo + 1 && $urandom_range(9, 0) < 8) begin
            if (style_left == 0) begin
               case ($urandom_range(3, 0))
                  0: group_style = GROUP_SPREAD;
                  1: group_style = GROUP_WRAP;
                  2: group_style = GROUP_LONG;
                  default: group_style = GROUP_SHORT;
               endcase
               style_left = 4 * $urandom_range(5, 2);
            end
            style_left--;
            case (group_style)
               GROUP_WRAP: begin
                  if (lo < 16384 && hi > 16384) it.period_ticks = 16'd16384;
                  else it.period_ticks = 16'($urandom_range(hi - 1, lo + 1));
               end
               GROUP_LONG:  it.period_ticks = 16'(hi - 1);
               GROUP_SHORT: it.period_ticks = 16'(lo + 1);
               default:     it.period_ticks = 16'($urandom_range(hi - 1, lo + 1));
            endcase
         end else begin
            case ($urandom_range(3, 0))
               0: it.period_ticks = 16'(lo);
               1: it.period_ticks = 16'(hi);
               default: ;
            endcase
         end
      end else if (r < 85) begin
         it.func = FUNC_TICK;
      end else if (r < 95) begin
         it.func = FUNC_SETPOINT;
         if ($urandom_range(9, 0) < 7)
            it.new_setpoint = 10'($urandom_range(SETPOINT_MAX, SETPOINT_MIN));
      end else begin
         it.func = FUNC_UNUSED;
      end
      return it;
   endfunction

   task automatic run_items(int unsigned target);
      req_type     it;
      bit          paused;
      int unsigned done;
      done   = 0;
      paused = 1'b0;
      while (done < target) begin
         it = make_item();
         send_item(it);
         done++;
         if (!paused && done >= target / 2) begin
            paused = 1'b1;
            settle();
         end
      end
   endtask

   initial begin : stimulus
      int unsigned lo;
      loop_shadow  = new();
      no_gaps      = 1'b0;
      hold_request = 1'b0;
      style_left   = 0;
      group_style  = GROUP_SPREAD;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_item(FUNC_TICK, 16'hFFFF, 10'd0, 10'd0);
      push_item(FUNC_TICK, 16'h0000, 10'd1023, 10'd999);
      push_item(FUNC_SETPOINT, 16'd0, 10'd0, 10'd9);
      push_item(FUNC_SETPOINT, 16'd0, 10'd0, 10'd10);
      push_item(FUNC_TICK, 16'd0, 10'd512, 10'd0);
      push_item(FUNC_TICK, 16'd0, 10'd700, 10'd0);
      push_item(FUNC_SETPOINT, 16'd0, 10'd0, 10'd999);
      push_item(FUNC_TICK, 16'd0, 10'd300, 10'd0);
      push_item(FUNC_SETPOINT, 16'd0, 10'd0, 10'd121);
      push_item(FUNC_SETPOINT, 16'd0, 10'd0, 10'd120);
      push_item(FUNC_TICK, 16'd0, 10'd1023, 10'd0);
      push_item(FUNC_TICK, 16'd0, 10'd1023, 10'd0);
      push_item(FUNC_UNUSED, 16'hA5A5, 10'h2AA, 10'h155);
      push_item(FUNC_PERIOD, 16'd200, 10'd0, 10'd0);
      push_item(FUNC_PERIOD, 16'd15625, 10'd0, 10'd0);
      push_item(FUNC_PERIOD, 16'd0, 10'd0, 10'd0);
      push_item(FUNC_PERIOD, 16'hFFFF, 10'd0, 10'd0);
      push_item(FUNC_PERIOD, 16'd201, 10'd0, 10'd0);
      push_item(FUNC_PERIOD, 16'd15624, 10'd0, 10'd0);
      push_item(FUNC_TICK, 16'd0, 10'd64, 10'd0);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: apply_cfg(16'd0, 16'hFFFF, 4'd15, 4'd15, 3'd0, 17'h1FFFF);
            1: apply_cfg(16'd0, 16'hFFFF, 4'd0, 4'd15, 3'd7, 17'd1);
            2: apply_cfg(16'hFFFF, 16'd0, 4'($urandom), 4'($urandom), 3'($urandom),
                         17'($urandom_range(131071, 1)));
            default: begin
               lo = $urandom_range(3000, 0);
               apply_cfg(16'(lo), 16'(lo + $urandom_range(20000, 50)), 4'($urandom),
                         4'($urandom), 3'($urandom), 17'($urandom_range(131071, 1)));
            end
         endcase
         no_gaps = (phase == 4);
         if (phase == 3) hold_request = 1'b1;
         run_items(115);
      end

      settle();
      repeat (40) @(posedge clock);
      if (loop_shadow.mismatches == 0 && loop_shadow.outstanding() == 0) begin
         $display("tb_encoder_speed_pi_controller: PASS");
      end else begin
         $display("tb_encoder_speed_pi_controller: FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/espc_pkg.sv
hdl/espc_csr.sv
hdl/espc_dp.sv
hdl/espc_ctrl.sv
hdl/encoder_speed_pi_controller.sv
tb/tb_encoder_speed_pi_controller.sv
